>>> sv/ccl_pkg.sv
package ccl_pkg;

  localparam int MAX_NODES = 256;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NODE_W    = 8;
  localparam int CFG_W     = 9;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [IDX_W-1:0] lbl_t;

  typedef struct packed {
    logic             shift;
    logic             update;
    lbl_t             keep;
    lbl_t             drop;
    logic [CNT_W-1:0] limit;
  } ccl_ctl_t;

endpackage

>>> sv/ccl_cell.sv
module ccl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ccl_pkg::lbl_t    idx,
  input  ccl_pkg::ccl_ctl_t ctl,
  input  ccl_pkg::lbl_t    nbr,
  output ccl_pkg::lbl_t    lbl
);
  import ccl_pkg::*;

  lbl_t lbl_r;
  logic hit;

  assign hit = ctl.update && (lbl_r == ctl.drop) && (CNT_W'(idx) < ctl.limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbl_r <= idx;
    end else if (ctl.shift) begin
      lbl_r <= nbr;
    end else if (hit) begin
      lbl_r <= ctl.keep;
    end
  end

  assign lbl = lbl_r;

endmodule

>>> sv/ccl_ctrl.sv
module ccl_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ccl_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [ccl_pkg::NODE_W-1:0] in_node_a,
  input  logic [ccl_pkg::NODE_W-1:0] in_node_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ccl_pkg::NODE_W-1:0] out_label,
  output logic                       out_merged,
  input  ccl_pkg::lbl_t               head_lbl,
  output ccl_pkg::ccl_ctl_t           ctl
);
  import ccl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic                op_r;
  logic [NODE_W-1:0]   a_r;
  logic [NODE_W-1:0]   b_r;
  logic [IDX_W-1:0]    cnt_r;
  lbl_t                keep_r;
  lbl_t                drop_r;
  logic [CFG_W-1:0]    count_r;
  logic                out_valid_r;
  logic [NODE_W-1:0]   out_label_r;
  logic                out_merged_r;
  logic [NODE_W-1:0]   res_label_r;
  logic                res_merged_r;

  logic [CNT_W-1:0]    n_eff;
  logic                a_ok;
  logic                b_ok;
  logic                merge;
  logic                in_tbl;
  logic                out_free;

  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_r) > MAX_NODES) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end

  assign a_ok     = 32'(a_r) < 32'(n_eff);
  assign b_ok     = 32'(b_r) < 32'(n_eff);
  assign merge    = (op_r == OP_EDGE) && a_ok && b_ok && (keep_r != drop_r);
  assign in_tbl   = 32'(a_r) < MAX_NODES;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CFG_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            a_r     <= in_node_a;
            b_r     <= in_node_b;
            cnt_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (32'(cnt_r) == 32'(a_r)) begin
            keep_r <= head_lbl;
          end
          if (32'(cnt_r) == 32'(b_r)) begin
            drop_r <= head_lbl;
          end
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == MAX_NODES - 1) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_merged_r <= merge;
          res_label_r  <= (merge || in_tbl) ? NODE_W'(keep_r) : a_r;
          state_r      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_label_r  <= res_label_r;
            out_merged_r <= res_merged_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_label  = out_label_r;
  assign out_merged = out_merged_r;

  assign ctl.shift  = (state_r == ST_SCAN);
  assign ctl.update = (state_r == ST_DECIDE) && merge;
  assign ctl.keep   = keep_r;
  assign ctl.drop   = drop_r;
  assign ctl.limit  = n_eff;

endmodule

>>> sv/connected_component_labeler.sv
// Connected-component labeler, quick-find union over a ring of label cells.
// Input channel (in_valid/in_ready): in_operation selects an edge (merge the
// groups of in_node_a and in_node_b) or a query (label of in_node_a).
// Output channel (out_valid/out_ready): one transaction per input
// transaction, out_label is the label of in_node_a after the operation and
// out_merged is set when an edge joined two distinct groups.
// cfg_wr_en/cfg_wr_data write the node count; write only while idle.
// From acceptance to a result, the label ring rotates once past the head
// cell to pick up the labels of in_node_a and in_node_b, then on a merge
// every cell in use that holds b's label takes a's label, all in parallel.
// One item is processed at a time; in_ready is high only while idle, so a
// new item waits until the last result is in the output register.
// A finished result sits in the output register; a new item is accepted
// while it waits, and that item's result holds in the block until the
// receiver takes the earlier one.
// Reset sets every node's label to its own index, the node count to 256
// and clears out_valid.
module connected_component_labeler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ccl_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [ccl_pkg::NODE_W-1:0] in_node_a,
  input  logic [ccl_pkg::NODE_W-1:0] in_node_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ccl_pkg::NODE_W-1:0] out_label,
  output logic                       out_merged
);
  import ccl_pkg::*;

  ccl_ctl_t ctl;
  lbl_t     lbl_w [MAX_NODES];

  ccl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_label    (out_label),
    .out_merged   (out_merged),
    .head_lbl     (lbl_w[0]),
    .ctl          (ctl)
  );

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    ccl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (lbl_t'(k)),
      .ctl   (ctl),
      .nbr   (lbl_w[(k + 1) % MAX_NODES]),
      .lbl   (lbl_w[k])
    );
  end

endmodule

>>> sv/ccl_checker.sv
module ccl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ccl_pkg::NODE_W-1:0] out_label,
  input logic                       out_merged
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_label) && $stable(out_merged))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a pending transaction");

  a_busy_1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  a_busy_2: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 !in_ready)
    else $error("transaction finished too early");

endmodule

bind connected_component_labeler ccl_checker u_ccl_checker (.*);

>>> tb/tb_connected_component_labeler.sv
`timescale 1ns / 100ps

module tb_connected_component_labeler;
  import ccl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned PHASE_ITEMS = 88;

  typedef struct {
    logic              op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } graph_item_t;

  typedef struct {
    logic [NODE_W-1:0] label;
    logic              merged;
  } label_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = OP_EDGE;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [NODE_W-1:0] out_label;
  logic              out_merged;

  connected_component_labeler u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_label    (out_label),
    .out_merged   (out_merged)
  );

  // group model
  logic [NODE_W-1:0] group_of [MAX_NODES];
  logic [CFG_W-1:0]  nodes_in_use;

  graph_item_t   edge_query_q [$];
  label_result_t pending_labels [$];

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  logic        in_took      = 1'b0;
  logic        quiet        = 1'b0;
  logic        hold_arm     = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned gap_cnt      = 0;
  int unsigned stall_cnt    = 0;
  int unsigned hold_cnt     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned live_nodes();
    int unsigned n;
    n = nodes_in_use;
    if (n == 0) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  task automatic predict_label(input graph_item_t it, output label_result_t r);
    int unsigned       n;
    logic [NODE_W-1:0] keep;
    logic [NODE_W-1:0] drop;
    n = live_nodes();
    r.merged = 1'b0;
    if (it.op == OP_EDGE && it.a < n && it.b < n) begin
      keep = group_of[it.a];
      drop = group_of[it.b];
      if (keep != drop) begin
        for (int i = 0; i < n; i++) begin
          if (group_of[i] == drop) group_of[i] = keep;
        end
        r.merged = 1'b1;
      end
    end
    r.label = group_of[it.a];
  endtask

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_item(input logic op, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b);
    graph_item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    edge_query_q = {edge_query_q, it};
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || pending_labels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= v;
    nodes_in_use = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      n    = live_nodes();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_item(OP_QUERY,
                   NODE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, n - 1)),
                   NODE_W'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        queue_item(OP_EDGE, NODE_W'($urandom_range(0, n - 1)),
                   NODE_W'($urandom_range(0, n - 1)));
      end else begin
        queue_item(OP_EDGE, NODE_W'($urandom_range(0, 255)),
                   NODE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // sender
  always @(negedge clk) begin : drive_items
    graph_item_t it;
    if (rst_n) begin
      if (in_valid && !in_took) begin
        // hold until the item is accepted
      end else if (gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        gap_cnt = $urandom_range(0, 2);
      end else if (edge_query_q.size() > 0) begin
        it = edge_query_q.pop_front();
        in_valid     <= 1'b1;
        in_operation <= it.op;
        in_node_a    <= it.a;
        in_node_b    <= it.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (hold_arm && !hold_done) begin
        out_ready <= 1'b0;
        hold_cnt  = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_cnt = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_ports
    graph_item_t   it;
    label_result_t want;
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pending_labels.size() == 0) begin
          flag_mismatch($sformatf("unexpected result label %0d merged %0d",
                                  out_label, out_merged));
        end else begin
          want = pending_labels.pop_front();
          if (out_label !== want.label)
            flag_mismatch($sformatf("out_label %0d, want %0d", out_label, want.label));
          if (out_merged !== want.merged)
            flag_mismatch($sformatf("out_merged %0d, want %0d", out_merged, want.merged));
        end
      end
      if (in_valid && in_ready) begin
        it.op = in_operation;
        it.a  = in_node_a;
        it.b  = in_node_b;
        predict_label(it, want);
        pending_labels = {pending_labels, want};
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_counts [9];
    for (int i = 0; i < MAX_NODES; i++) group_of[i] = NODE_W'(i);
    nodes_in_use = CFG_W'(256);
    phase_counts = '{256, 2, 16, 511, 1, 100, 257, 0, 256};
    phase_counts[5] = $urandom_range(3, 255);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    queue_item(OP_QUERY, 0, 255);
    queue_item(OP_QUERY, 255, 0);
    queue_item(OP_EDGE, 0, 255);
    queue_item(OP_EDGE, 255, 0);
    queue_item(OP_QUERY, 255, 255);
    queue_item(OP_EDGE, 7, 7);
    queue_item(OP_EDGE, 1, 2);
    queue_item(OP_EDGE, 2, 3);
    queue_item(OP_QUERY, 3, 170);
    queue_item(OP_EDGE, 128, 127);
    queue_item(OP_EDGE, 255, 128);

    write_node_count(0);
    queue_item(OP_EDGE, 0, 0);
    queue_item(OP_EDGE, 0, 1);
    queue_item(OP_QUERY, 200, 85);
    queue_item(OP_QUERY, 3, 0);

    write_node_count(3);
    queue_item(OP_EDGE, 2, 3);
    queue_item(OP_EDGE, 3, 2);
    queue_item(OP_EDGE, 2, 0);
    queue_item(OP_QUERY, 255, 0);
    queue_item(OP_QUERY, 0, 0);

    write_node_count(511);
    queue_item(OP_EDGE, 254, 253);
    queue_item(OP_QUERY, 253, 0);
    queue_item(OP_EDGE, 170, 85);
    queue_item(OP_QUERY, 85, 255);

    for (int p = 0; p < 9; p++) begin
      write_node_count(CFG_W'(phase_counts[p]));
      if (p == 3) hold_arm = 1'b1;
      if (p == 8) quiet = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (300) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
